// ===== hw/rtl/gbfcu_pkg.sv =====
// ----------------------------------------------------------------------------
// GPIO bit-field command unit package
// Shared widths, opcode codes and the command record used by all modules.
// ----------------------------------------------------------------------------
package gbfcu_pkg;

  // Fixed widths of the command and result fields.
  localparam int OPCODE_W = 4;
  localparam int FIELD_W  = 8;

  // Number of ports and the default width of one port.
  localparam int PORT_COUNT     = 2;
  localparam int PORT_WIDTH_DEF = 8;

  // Command opcodes. Codes nine to fifteen behave as no operation.
  typedef enum logic [OPCODE_W-1:0] {
    OP_NONE     = 4'd0,
    OP_SET      = 4'd1,
    OP_CLEAR    = 4'd2,
    OP_INVERT   = 4'd3,
    OP_INCREASE = 4'd4,
    OP_DECREASE = 4'd5,
    OP_TRISTATE = 4'd6,
    OP_MEMORIZE = 4'd7,
    OP_RECALL   = 4'd8
  } opcode_t;

  // One command as held in the input register.
  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic                port_select;
    logic [FIELD_W-1:0]  bit_mask;
    logic [FIELD_W-1:0]  field_data;
  } cmd_t;

  // Status from the field logic to the top level.
  typedef struct packed {
    logic applied;
    logic port_write;
    logic memorize;
    logic recall;
  } alu_status_t;

endpackage

// ===== hw/rtl/gbfcu_if.sv =====
// ----------------------------------------------------------------------------
// GPIO bit-field command unit channel interfaces
// Valid/ready channels for commands and for results.
// ----------------------------------------------------------------------------

// Command channel.
interface gbfcu_cmd_if import gbfcu_pkg::*; ;
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic                port_select;
  logic [FIELD_W-1:0]  bit_mask;
  logic [FIELD_W-1:0]  field_data;

  modport source (output valid, output opcode, output port_select,
                  output bit_mask, output field_data, input ready);
  modport sink   (input valid, input opcode, input port_select,
                  input bit_mask, input field_data, output ready);
endinterface

// Result channel.
interface gbfcu_res_if import gbfcu_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] level_value;
  logic [FIELD_W-1:0] direction_value;
  logic               applied;

  modport source (output valid, output level_value, output direction_value,
                  output applied, input ready);
  modport sink   (input valid, input level_value, input direction_value,
                  input applied, output ready);
endinterface

// ===== hw/rtl/gbfcu_field_alu.sv =====
// ----------------------------------------------------------------------------
// GPIO bit-field command unit field logic
// Applies one command to the level and direction of the selected port.
// ----------------------------------------------------------------------------
module gbfcu_field_alu import gbfcu_pkg::*; #(
  parameter int PORT_WIDTH = PORT_WIDTH_DEF
) (
  input  cmd_t                  cmd,
  input  logic [PORT_WIDTH-1:0] lvl_i,
  input  logic [PORT_WIDTH-1:0] dir_i,
  output logic [PORT_WIDTH-1:0] lvl_o,
  output logic [PORT_WIDTH-1:0] dir_o,
  output alu_status_t           status
);

  localparam int OFF_W = (PORT_WIDTH > 1) ? $clog2(PORT_WIDTH) : 1;

  logic [PORT_WIDTH-1:0] mask;
  logic [PORT_WIDTH-1:0] low_bit;
  logic [OFF_W-1:0]      offset;
  logic [PORT_WIDTH-1:0] set_field;
  logic [PORT_WIDTH-1:0] inc_field;
  logic [PORT_WIDTH-1:0] dec_field;
  logic                  zero_mask;

  // Mask bits above the port width are dropped.
  assign mask      = PORT_WIDTH'(cmd.bit_mask);
  assign zero_mask = (mask == '0);

  // Lowest set bit of the mask as a one-hot word.
  assign low_bit = mask & (~mask + PORT_WIDTH'(1));

  // Offset of the field: encode the one-hot lowest bit.
  always_comb begin
    offset = '0;
    for (int i = 0; i < PORT_WIDTH; i++) begin
      if (low_bit[i]) begin
        offset = offset | OFF_W'(i);
      end
    end
  end

  // Aligned data for set; counting within the field wraps through the mask.
  assign set_field = (PORT_WIDTH'(cmd.field_data) << offset) & mask;
  assign inc_field = ((lvl_i & mask) + low_bit) & mask;
  assign dec_field = ((lvl_i & mask) - low_bit) & mask;

  // Opcode decode and the new port registers.
  always_comb begin
    lvl_o             = lvl_i;
    dir_o             = dir_i;
    status.applied    = 1'b1;
    status.port_write = 1'b0;
    status.memorize   = 1'b0;
    status.recall     = 1'b0;
    unique case (cmd.opcode) inside
      OP_SET: begin
        lvl_o             = (lvl_i & ~mask) | set_field;
        dir_o             = dir_i | mask;
        status.applied    = !zero_mask;
        status.port_write = 1'b1;
      end
      OP_CLEAR: begin
        lvl_o             = lvl_i & ~mask;
        dir_o             = dir_i | mask;
        status.port_write = 1'b1;
      end
      OP_INVERT: begin
        lvl_o             = lvl_i ^ mask;
        dir_o             = dir_i | mask;
        status.port_write = 1'b1;
      end
      OP_INCREASE: begin
        lvl_o             = (lvl_i & ~mask) | inc_field;
        dir_o             = dir_i | mask;
        status.applied    = !zero_mask;
        status.port_write = 1'b1;
      end
      OP_DECREASE: begin
        lvl_o             = (lvl_i & ~mask) | dec_field;
        dir_o             = dir_i | mask;
        status.applied    = !zero_mask;
        status.port_write = 1'b1;
      end
      OP_TRISTATE: begin
        lvl_o             = lvl_i & ~mask;
        dir_o             = dir_i & ~mask;
        status.port_write = 1'b1;
      end
      OP_MEMORIZE: begin
        status.memorize = 1'b1;
      end
      OP_RECALL: begin
        status.recall = 1'b1;
      end
      default: begin
        // No operation, including the unused codes.
      end
    endcase
  end

endmodule

// ===== hw/rtl/gpio_bit_field_command_unit.sv =====
// ----------------------------------------------------------------------------
// GPIO bit-field command unit
// Two-stage command pipeline over the level and direction registers of two
// ports and their snapshot.
// ----------------------------------------------------------------------------
// Each command gives one result: the selected port's level and direction
// after the command. A command is captured in an input register at its
// transfer and applied, once the result register is free, by a
// read-modify-write of the port registers, which loads the result
// register. The unit takes one command per cycle for as long as results
// are taken; a result that waits holds the next command in the input
// register. Port registers and snapshot reset to zero, so all pins start
// as inputs at level zero.
module gpio_bit_field_command_unit import gbfcu_pkg::*; #(
  parameter int PORT_WIDTH = PORT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  gbfcu_cmd_if.sink   in_cmd,
  gbfcu_res_if.source out_res
);

  // Port and snapshot registers.
  logic [PORT_WIDTH-1:0] port_level_r [PORT_COUNT];
  logic [PORT_WIDTH-1:0] port_dir_r   [PORT_COUNT];
  logic [PORT_WIDTH-1:0] snap_level_r [PORT_COUNT];
  logic [PORT_WIDTH-1:0] snap_dir_r   [PORT_COUNT];

  // Input register.
  cmd_t cmd_r;
  logic s1_valid_r;
  logic s1_valid_nxt;

  // Result register.
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [FIELD_W-1:0] level_r;
  logic [FIELD_W-1:0] dir_out_r;
  logic               applied_r;

  logic                  advance;
  logic                  in_fire;
  logic                  s2_fire;
  logic [PORT_WIDTH-1:0] alu_lvl;
  logic [PORT_WIDTH-1:0] alu_dir;
  logic [PORT_WIDTH-1:0] res_lvl;
  logic [PORT_WIDTH-1:0] res_dir;
  alu_status_t           alu_status;

  // Handshake: the result register frees when empty or when taken.
  assign advance      = !out_valid_r || out_res.ready;
  assign in_cmd.ready = !s1_valid_r || advance;
  assign in_fire      = in_cmd.valid && in_cmd.ready;
  assign s2_fire      = s1_valid_r && advance;

  // Field logic on the selected port.
  gbfcu_field_alu #(
    .PORT_WIDTH (PORT_WIDTH)
  ) u_field_alu (
    .cmd    (cmd_r),
    .lvl_i  (port_level_r[cmd_r.port_select]),
    .dir_i  (port_dir_r[cmd_r.port_select]),
    .lvl_o  (alu_lvl),
    .dir_o  (alu_dir),
    .status (alu_status)
  );

  // Reported registers: recall reports the restored snapshot.
  always_comb begin
    if (alu_status.recall) begin
      res_lvl = snap_level_r[cmd_r.port_select];
      res_dir = snap_dir_r[cmd_r.port_select];
    end else begin
      res_lvl = alu_lvl;
      res_dir = alu_dir;
    end
  end

  // Valid flags of both stages.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = advance ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Command capture.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r.opcode      <= in_cmd.opcode;
      cmd_r.port_select <= in_cmd.port_select;
      cmd_r.bit_mask    <= in_cmd.bit_mask;
      cmd_r.field_data  <= in_cmd.field_data;
    end
  end

  // Port and snapshot update when a command leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PORT_COUNT; i++) begin
        port_level_r[i] <= '0;
        port_dir_r[i]   <= '0;
        snap_level_r[i] <= '0;
        snap_dir_r[i]   <= '0;
      end
    end else if (s2_fire) begin
      if (alu_status.port_write) begin
        port_level_r[cmd_r.port_select] <= alu_lvl;
        port_dir_r[cmd_r.port_select]   <= alu_dir;
      end
      if (alu_status.memorize) begin
        for (int i = 0; i < PORT_COUNT; i++) begin
          snap_level_r[i] <= port_level_r[i];
          snap_dir_r[i]   <= port_dir_r[i];
        end
      end
      if (alu_status.recall) begin
        for (int i = 0; i < PORT_COUNT; i++) begin
          port_level_r[i] <= snap_level_r[i];
          port_dir_r[i]   <= snap_dir_r[i];
        end
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (s2_fire) begin
      level_r   <= FIELD_W'(res_lvl);
      dir_out_r <= FIELD_W'(res_dir);
      applied_r <= alu_status.applied;
    end
  end

  assign out_res.valid           = out_valid_r;
  assign out_res.level_value     = level_r;
  assign out_res.direction_value = dir_out_r;
  assign out_res.applied         = applied_r;

  // A held command must stay in the input register until it moves on.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r)
    else $error("command dropped from input register while stalled");

  // A rejected command leaves the selected port untouched.
  a_not_applied_stable: assert property (@(posedge clk) disable iff (!rst_n)
    s2_fire && !alu_status.applied |=>
      $stable(port_level_r[0]) && $stable(port_level_r[1]) &&
      $stable(port_dir_r[0]) && $stable(port_dir_r[1]))
    else $error("rejected command changed a port register");

  // Tristate reports the masked field as input.
  a_tristate_dir: assert property (@(posedge clk) disable iff (!rst_n)
    s2_fire && (cmd_r.opcode == OP_TRISTATE) |=>
      out_valid_r && ((dir_out_r & $past(cmd_r.bit_mask)) == '0))
    else $error("tristate left a masked pin as output");

  // State changes only when a command is applied.
  a_idle_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !s2_fire |=> $stable(snap_level_r[0]) && $stable(snap_level_r[1]) &&
      $stable(port_level_r[0]) && $stable(port_level_r[1]))
    else $error("register changed without a command");

endmodule
